/* rtl/scu_pkg.sv */
// Shared types and constants for the control transfer unit.
// Used by scu_exec and sparc_control_transfer_unit; no other dependencies.
package scu_pkg;

    // instruction kinds carried in the input tuser
    typedef enum logic [2:0] {
        CMD_CALL   = 3'd0,
        CMD_SETHI  = 3'd1,
        CMD_NOP    = 3'd2,
        CMD_UNIMP  = 3'd3,
        CMD_BRANCH = 3'd4
    } cmd_t;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_EXEC    = 2'd0,
        ST_HALT    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    // low three bits of the Bicc condition; bit 3 inverts the test
    localparam logic [2:0] CB_NEVER = 3'd0;
    localparam logic [2:0] CB_EQ    = 3'd1;
    localparam logic [2:0] CB_LE    = 3'd2;
    localparam logic [2:0] CB_LT    = 3'd3;
    localparam logic [2:0] CB_LEU   = 3'd4;
    localparam logic [2:0] CB_CS    = 3'd5;
    localparam logic [2:0] CB_NEG   = 3'd6;
    localparam logic [2:0] CB_VS    = 3'd7;
    localparam logic [3:0] COND_BA  = 4'd8;

    localparam int unsigned ADDR_W = 32;
    localparam logic [4:0]  LINK_REG = 5'd15;       // %o7
    localparam logic [ADDR_W-1:0] PC_RESET  = 32'd0;
    localparam logic [ADDR_W-1:0] NPC_RESET = 32'd4;
    localparam logic [ADDR_W-1:0] INSN_STEP = 32'd4;
    localparam logic [ADDR_W-1:0] SKIP_STEP = 32'd8;

    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned OUT_USER_W = 2;

    // one decoded instruction with condition codes
    typedef struct packed {
        logic [2:0]        cmd;
        logic [3:0]        cond;
        logic              annul;
        logic [ADDR_W-1:0] target;
        logic [21:0]       imm_high;
        logic [4:0]        dest_reg;
        logic              flag_n;
        logic              flag_z;
        logic              flag_v;
        logic              flag_c;
    } insn_t;

    // one result item
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] next_pc;
        logic [ADDR_W-1:0] next_npc;
        logic              reg_write;
        logic [4:0]        reg_index;
        logic [ADDR_W-1:0] reg_data;
    } result_t;

endpackage

/* rtl/scu_exec.sv */
// Next-pc, register write and status logic for one instruction.
// Purely combinational; depends on scu_pkg.
module scu_exec (
    input  scu_pkg::insn_t                  insn,
    input  logic [scu_pkg::ADDR_W-1:0]      pc,
    input  logic [scu_pkg::ADDR_W-1:0]      npc,
    output scu_pkg::result_t                res
);
    import scu_pkg::*;

    logic              base_hit;
    logic              taken;
    logic [ADDR_W-1:0] npc_plus4;
    logic [ADDR_W-1:0] npc_plus8;
    logic [ADDR_W-1:0] tgt_plus4;

    // integer condition code test
    always_comb
    begin
        case (insn.cond[2:0])
            CB_NEVER: base_hit = 1'b0;
            CB_EQ:    base_hit = insn.flag_z;
            CB_LE:    base_hit = insn.flag_z | (insn.flag_n ^ insn.flag_v);
            CB_LT:    base_hit = insn.flag_n ^ insn.flag_v;
            CB_LEU:   base_hit = insn.flag_c | insn.flag_z;
            CB_CS:    base_hit = insn.flag_c;
            CB_NEG:   base_hit = insn.flag_n;
            CB_VS:    base_hit = insn.flag_v;
            default:  base_hit = 1'b0;
        endcase
        taken = insn.cond[3] ? !base_hit : base_hit;
    end

    // address sums wrap at 32 bits
    assign npc_plus4 = npc + INSN_STEP;
    assign npc_plus8 = npc + SKIP_STEP;
    assign tgt_plus4 = insn.target + INSN_STEP;

    // instruction decode and next state
    always_comb
    begin
        res           = '0;
        res.status    = ST_EXEC;
        res.next_pc   = pc;
        res.next_npc  = npc;
        case (insn.cmd)
            CMD_CALL:
            begin
                res.next_pc   = npc;
                res.next_npc  = insn.target;
                res.reg_write = 1'b1;
                res.reg_index = LINK_REG;
                res.reg_data  = pc;
            end
            CMD_SETHI:
            begin
                res.next_pc   = npc;
                res.next_npc  = npc_plus4;
                res.reg_write = 1'b1;
                res.reg_index = insn.dest_reg;
                res.reg_data  = {insn.imm_high, 10'd0};
            end
            CMD_NOP:
            begin
                res.next_pc  = npc;
                res.next_npc = npc_plus4;
            end
            CMD_UNIMP:
            begin
                res.status = ST_HALT;
            end
            CMD_BRANCH:
            begin
                if (insn.cond == COND_BA && insn.annul)
                begin
                    // ba,a jumps at once and drops the delay slot
                    res.next_pc  = insn.target;
                    res.next_npc = tgt_plus4;
                end
                else if (taken)
                begin
                    res.next_pc  = npc;
                    res.next_npc = insn.target;
                end
                else if (insn.annul)
                begin
                    // untaken annulled branch skips its delay slot
                    res.next_pc  = npc_plus4;
                    res.next_npc = npc_plus8;
                end
                else
                begin
                    res.next_pc  = npc;
                    res.next_npc = npc_plus4;
                end
            end
            default:
            begin
                res.status = ST_UNKNOWN;
            end
        endcase
    end

endmodule

/* rtl/sparc_control_transfer_unit.sv */
// SPARC control transfer unit: input register, execute logic, result register.
// Depends on scu_pkg and scu_exec.
//
// Usage:
//   Each input transaction carries one decoded instruction (kind in s_axis_tuser,
//   condition, annul bit, target, sethi immediate and destination, condition
//   codes in s_axis_tdata). Each one yields exactly one output transaction with
//   the new pc and npc, an optional register write and a status in m_axis_tuser.
//   After acceptance the instruction sits in the input register while the execute
//   logic feeds the result register, whose load raises m_axis_tvalid. Throughput
//   is one instruction per cycle while m_axis_tready is held high; the pc/npc
//   registers are updated in the same cycle the result register loads, so the
//   next instruction sees them at once.
//   When the receiver holds m_axis_tready low the result register holds, the
//   input register fills, and s_axis_tready drops; no transaction is lost.
//   Reset clears both stages and sets pc to 0 and npc to 4.
module sparc_control_transfer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cond, annul, target, imm_high, dest_reg, flag_n, flag_z, flag_v, flag_c, zero pad
    input  logic [scu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd
    input  logic [scu_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // next_pc, next_npc, reg_write, reg_index, reg_data, zero pad
    output logic [scu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic [scu_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import scu_pkg::*;

    logic              in_valid_reg;
    insn_t             insn_reg;
    insn_t             insn_next;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           res;
    logic [ADDR_W-1:0] pc_reg;
    logic [ADDR_W-1:0] npc_reg;
    logic              out_load;
    logic              in_load;

    // handshake: result stage loads from a full input stage when empty or being drained
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // unpack the input transaction
    always_comb
    begin
        insn_next.cmd      = s_axis_tuser;
        insn_next.cond     = s_axis_tdata[3:0];
        insn_next.annul    = s_axis_tdata[4];
        insn_next.target   = s_axis_tdata[36:5];
        insn_next.imm_high = s_axis_tdata[58:37];
        insn_next.dest_reg = s_axis_tdata[63:59];
        insn_next.flag_n   = s_axis_tdata[64];
        insn_next.flag_z   = s_axis_tdata[65];
        insn_next.flag_v   = s_axis_tdata[66];
        insn_next.flag_c   = s_axis_tdata[67];
    end

    // execute logic
    scu_exec u_exec (
        .insn (insn_reg),
        .pc   (pc_reg),
        .npc  (npc_reg),
        .res  (res)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_RESET;
            npc_reg       <= NPC_RESET;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (out_load)
                in_valid_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                pc_reg        <= res.next_pc;
                npc_reg       <= res.next_npc;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
            insn_reg <= insn_next;
        if (out_load)
            out_reg <= res;
    end

    // pack the output transaction
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {2'b00, out_reg.reg_data, out_reg.reg_index, out_reg.reg_write,
                            out_reg.next_npc, out_reg.next_pc};

    // a stalled result keeps the pc state frozen
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(pc_reg) && $stable(npc_reg))
        else $error("pc state moved while result stalled");

    // the held result always matches the architectural state
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.next_pc == pc_reg && out_reg.next_npc == npc_reg)
        else $error("result pc/npc differs from state");

    // halt or unknown instruction leaves the state alone
    a_halt_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res.status != ST_EXEC |=> $stable(pc_reg) && $stable(npc_reg))
        else $error("state advanced on halt or unknown instruction");

    // no register write means clean write fields
    a_no_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.reg_write |-> out_reg.reg_index == '0 && out_reg.reg_data == '0)
        else $error("write fields set without a register write");

endmodule

/* verif/tb_top.sv */
// Self-checking bench for sparc_control_transfer_unit: directed and random instructions.
// Depends on scu_pkg and the unit's RTL; an in-bench pc/npc model predicts every result.
module tb_top;
    import scu_pkg::*;

    localparam logic [2:0] CMD_TOP   = 3'd7;       // highest command code
    localparam int         RAND_ITEMS = 1250;
    localparam int         HOLD_CYCLES = 300;
    localparam int         HOLD_AFTER  = 400;
    localparam int         DRAIN_CYCLES = 10;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [IN_USER_W-1:0]    s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [OUT_USER_W-1:0]   m_axis_tuser;

    sparc_control_transfer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    insn_t   pending_insns[$];
    result_t expected_results[$];

    // model of the pc/npc pair
    logic [ADDR_W-1:0] model_pc = PC_RESET;
    logic [ADDR_W-1:0] model_npc = NPC_RESET;

    int error_count = 0;
    int mismatch_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int kind_count[8] = '{default: 0};
    int skip_count = 0;
    int taken_count = 0;

    // bicc condition test; bit 3 inverts the low-three-bit test
    function automatic logic cond_true(input logic [3:0] c, input logic n, input logic z,
                                       input logic v, input logic cy);
        logic base;
        case (c[2:0])
            CB_NEVER: base = 1'b0;
            CB_EQ:    base = z;
            CB_LE:    base = z || (n != v);
            CB_LT:    base = (n != v);
            CB_LEU:   base = cy || z;
            CB_CS:    base = cy;
            CB_NEG:   base = n;
            default:  base = v;
        endcase
        return c[3] ? !base : base;
    endfunction

    // expected result of one instruction; advances the model pc/npc
    function automatic result_t predict_transfer(input insn_t ins);
        result_t r;
        r.status    = ST_EXEC;
        r.next_pc   = model_pc;
        r.next_npc  = model_npc;
        r.reg_write = 1'b0;
        r.reg_index = '0;
        r.reg_data  = '0;
        case (ins.cmd)
            CMD_CALL:
            begin
                r.next_pc   = model_npc;
                r.next_npc  = ins.target;
                r.reg_write = 1'b1;
                r.reg_index = LINK_REG;
                r.reg_data  = model_pc;
            end
            CMD_SETHI:
            begin
                r.next_pc   = model_npc;
                r.next_npc  = model_npc + INSN_STEP;
                r.reg_write = 1'b1;
                r.reg_index = ins.dest_reg;
                r.reg_data  = {ins.imm_high, 10'd0};
            end
            CMD_NOP:
            begin
                r.next_pc  = model_npc;
                r.next_npc = model_npc + INSN_STEP;
            end
            CMD_UNIMP:
                r.status = ST_HALT;
            CMD_BRANCH:
            begin
                if (ins.cond == COND_BA && ins.annul)
                begin
                    // branch always with annul: jump now, delay slot dropped
                    r.next_pc  = ins.target;
                    r.next_npc = ins.target + INSN_STEP;
                    taken_count++;
                end
                else if (cond_true(ins.cond, ins.flag_n, ins.flag_z, ins.flag_v, ins.flag_c))
                begin
                    r.next_pc  = model_npc;
                    r.next_npc = ins.target;
                    taken_count++;
                end
                else if (ins.annul)
                begin
                    // untaken with annul: delay slot skipped
                    r.next_pc  = model_npc + INSN_STEP;
                    r.next_npc = model_npc + SKIP_STEP;
                    skip_count++;
                end
                else
                begin
                    r.next_pc  = model_npc;
                    r.next_npc = model_npc + INSN_STEP;
                end
            end
            default:
                r.status = ST_UNKNOWN;
        endcase
        model_pc  = r.next_pc;
        model_npc = r.next_npc;
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_insn(input insn_t ins);
        return {4'd0, ins.flag_c, ins.flag_v, ins.flag_z, ins.flag_n, ins.dest_reg,
                ins.imm_high, ins.target, ins.annul, ins.cond};
    endfunction

    task automatic add_insn(input logic [2:0] cmd, input logic [3:0] cond, input logic annul,
                            input logic [31:0] target, input logic [21:0] imm,
                            input logic [4:0] dst, input logic [3:0] nzvc);
        insn_t ins;
        ins.cmd      = cmd;
        ins.cond     = cond;
        ins.annul    = annul;
        ins.target   = target;
        ins.imm_high = imm;
        ins.dest_reg = dst;
        ins.flag_n   = nzvc[3];
        ins.flag_z   = nzvc[2];
        ins.flag_v   = nzvc[1];
        ins.flag_c   = nzvc[0];
        pending_insns.push_back(ins);
    endtask

    // random instruction, mostly branches with some of every other kind
    function automatic insn_t rand_insn();
        insn_t ins;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            ins.cmd = CMD_CALL;
        else if (pick < 23)
            ins.cmd = CMD_SETHI;
        else if (pick < 35)
            ins.cmd = CMD_NOP;
        else if (pick < 38)
            ins.cmd = CMD_UNIMP;
        else if (pick < 41)
            ins.cmd = 3'($urandom_range(CMD_BRANCH + 1, CMD_TOP));
        else
            ins.cmd = CMD_BRANCH;
        ins.cond     = 4'($urandom_range(0, 15));
        ins.annul    = 1'($urandom_range(0, 1));
        ins.target   = ($urandom_range(0, 9) == 0) ? (32'hFFFF_FFF0 | 32'($urandom_range(0, 15)))
                                                    : 32'($urandom);
        ins.imm_high = 22'($urandom);
        ins.dest_reg = 5'($urandom_range(0, 31));
        ins.flag_n   = 1'($urandom_range(0, 1));
        ins.flag_z   = 1'($urandom_range(0, 1));
        ins.flag_v   = 1'($urandom_range(0, 1));
        ins.flag_c   = 1'($urandom_range(0, 1));
        return ins;
    endfunction

    // sender: bursts of random length with random gaps in between
    int     burst_left = 1;
    int     gap_left = 0;
    insn_t  cur_insn = '0;

    always @(posedge clk)
    begin : driver
        logic nv;
        if (rst_n)
        begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_transfer(cur_insn));
                kind_count[cur_insn.cmd]++;
                accepted_count++;
                nv = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_insns.size() > 0)
                begin
                    cur_insn = pending_insns.pop_front();
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= pack_insn(cur_insn);
            s_axis_tuser  <= cur_insn.cmd;
        end
    end

    // receiver: changing stall patterns plus one long hold-off
    int               rx_mode = 0;
    int               rx_mode_left = 0;
    logic [15:0]      rx_mask = 16'h1;
    logic [3:0]       rx_phase = '0;
    int               hold_left = 0;
    logic             hold_done = 1'b0;

    always @(posedge clk)
    begin : receiver
        logic rdy;
        if (rst_n)
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(32, 256);
                rx_mask = 16'($urandom) | 16'h1;
            end
            else
                rx_mode_left--;
            if (!hold_done && accepted_count >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    default:
                    begin
                        rdy = rx_mask[rx_phase];
                        rx_phase++;
                    end
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // monitor: compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin : monitor
        result_t exp_r;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status    = status_t'(m_axis_tuser);
            got.next_pc   = m_axis_tdata[31:0];
            got.next_npc  = m_axis_tdata[63:32];
            got.reg_write = m_axis_tdata[64];
            got.reg_index = m_axis_tdata[69:65];
            got.reg_data  = m_axis_tdata[101:70];
            if (expected_results.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status=%0d pc=%h npc=%h wr=%b idx=%0d data=%h",
                             got.status, got.next_pc, got.next_npc, got.reg_write,
                             got.reg_index, got.reg_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                checked_count++;
                if (got.status !== exp_r.status || got.next_pc !== exp_r.next_pc ||
                    got.next_npc !== exp_r.next_npc || got.reg_write !== exp_r.reg_write ||
                    got.reg_index !== exp_r.reg_index || got.reg_data !== exp_r.reg_data)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch on result %0d:", checked_count);
                        $display("  expected status=%0d pc=%h npc=%h wr=%b idx=%0d data=%h",
                                 exp_r.status, exp_r.next_pc, exp_r.next_npc,
                                 exp_r.reg_write, exp_r.reg_index, exp_r.reg_data);
                        $display("  actual   status=%0d pc=%h npc=%h wr=%b idx=%0d data=%h",
                                 got.status, got.next_pc, got.next_npc,
                                 got.reg_write, got.reg_index, got.reg_data);
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        logic [2:0] k;
        // directed: every kind, field extremes, annul corner cases, address wrap
        add_insn(CMD_NOP, 4'd0, 1'b0, 32'd0, 22'd0, 5'd0, 4'b0000);
        add_insn(CMD_CALL, 4'd0, 1'b0, 32'h0000_0000, 22'd0, 5'd0, 4'b0000);
        add_insn(CMD_CALL, 4'hF, 1'b1, 32'hFFFF_FFFF, 22'h3FFFFF, 5'd31, 4'b1111);
        add_insn(CMD_NOP, 4'd0, 1'b0, 32'd0, 22'd0, 5'd0, 4'b0000);
        add_insn(CMD_SETHI, 4'd0, 1'b0, 32'd0, 22'h3FFFFF, 5'd31, 4'b0000);
        add_insn(CMD_SETHI, 4'hF, 1'b1, 32'hFFFF_FFFF, 22'd0, 5'd0, 4'b1111);
        add_insn(CMD_UNIMP, 4'd0, 1'b0, 32'h1234_5678, 22'h155555, 5'd7, 4'b1010);
        for (k = 3'(CMD_BRANCH + 1); k != 3'd0; k++)
            add_insn(k, 4'd8, 1'b1, 32'hDEAD_BEEF, 22'h2AAAAA, 5'd21, 4'b0101);
        add_insn(CMD_BRANCH, COND_BA, 1'b1, 32'hFFFF_FFFC, 22'd0, 5'd0, 4'b0000);
        add_insn(CMD_BRANCH, 4'd0, 1'b1, 32'h0000_0400, 22'd0, 5'd0, 4'b1111);
        add_insn(CMD_BRANCH, 4'd0, 1'b0, 32'h0000_0400, 22'd0, 5'd0, 4'b1111);
        add_insn(CMD_BRANCH, COND_BA, 1'b0, 32'h0000_0100, 22'd0, 5'd0, 4'b0000);
        add_insn(CMD_BRANCH, 4'd1, 1'b1, 32'h0000_0200, 22'd0, 5'd0, 4'b0100);
        add_insn(CMD_BRANCH, 4'd9, 1'b1, 32'h0000_0300, 22'd0, 5'd0, 4'b0100);
        add_insn(CMD_BRANCH, 4'd13, 1'b0, 32'h0000_0500, 22'd0, 5'd0, 4'b0001);
        add_insn(CMD_CALL, 4'd0, 1'b0, 32'hFFFF_FFF8, 22'd0, 5'd0, 4'b0000);
        add_insn(CMD_BRANCH, 4'd0, 1'b1, 32'h0000_0600, 22'd0, 5'd0, 4'b0000);
        add_insn(CMD_BRANCH, 4'd2, 1'b0, 32'h0000_0700, 22'd0, 5'd0, 4'b1000);
        add_insn(CMD_BRANCH, 4'd7, 1'b0, 32'hAAAA_5555, 22'h2AAAAA, 5'd10, 4'b1111);
        add_insn(CMD_SETHI, 4'd5, 1'b1, 32'h5555_AAAA, 22'h155555, 5'd21, 4'b0110);
        // random part
        repeat (RAND_ITEMS)
            pending_insns.push_back(rand_insn());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_insns.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() > 0)
            error_count++;
        $display("covered %0d instructions: %0d call, %0d sethi, %0d nop, %0d unimp, %0d branch",
                 accepted_count, kind_count[CMD_CALL], kind_count[CMD_SETHI],
                 kind_count[CMD_NOP], kind_count[CMD_UNIMP], kind_count[CMD_BRANCH]);
        $display("unknown kinds %0d, branches taken %0d, annulled skips %0d, %0d mismatches",
                 kind_count[5] + kind_count[6] + kind_count[7], taken_count, skip_count,
                 mismatch_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
